>>> rtl/cses_pkg.sv
// ----------------------------------------------------------------------------
// cses_pkg
// shared types and constants of the can signal extract and scale core
// ----------------------------------------------------------------------------
package cses_pkg;

  localparam int unsigned PAYLOAD_BYTES = 8;
  localparam int unsigned PAYLOAD_W     = 64;
  localparam int unsigned RAW_W         = 64;
  localparam int unsigned SCALE_W       = 32;
  localparam int unsigned VALUE_W       = 48;
  localparam int unsigned WIDE_W        = 64;
  localparam int unsigned APB_ADDR_W    = 6;
  localparam int unsigned APB_DATA_W    = 64;
  localparam int unsigned IN_TDATA_W    = 64;
  localparam int unsigned OUT_TDATA_W   = 112;
  localparam int unsigned N_STAGES      = 7;

  // valid payload bits; bytes at or above PAYLOAD_BYTES read as zero
  localparam logic [PAYLOAD_W-1:0] PAYLOAD_MASK =
    (PAYLOAD_BYTES >= 8) ? {PAYLOAD_W{1'b1}}
                         : PAYLOAD_W'((65'd1 << (8 * PAYLOAD_BYTES)) - 65'd1);

  // saturation bound of the product magnitude
  localparam logic [WIDE_W-1:0] PROD_CAP = WIDE_W'(64'd1 << 62);

  typedef enum logic [2:0] {
    REG_START_BIT    = 3'd0,
    REG_BIT_LENGTH   = 3'd1,
    REG_INTEL_ORDER  = 3'd2,
    REG_IS_UNSIGNED  = 3'd3,
    REG_SCALE_FACTOR = 3'd4,
    REG_OFFSET_VALUE = 3'd5,
    REG_MIN_LIMIT    = 3'd6,
    REG_MAX_LIMIT    = 3'd7
  } reg_idx_e;

  localparam logic [5:0]         START_BIT_RST  = 6'd0;
  localparam logic [6:0]         BIT_LENGTH_RST = 7'd8;
  localparam logic [SCALE_W-1:0] SCALE_RST      = 32'h0001_0000;
  localparam logic [VALUE_W-1:0] OFFSET_RST     = '0;
  localparam logic [VALUE_W-1:0] MIN_RST        = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [VALUE_W-1:0] MAX_RST        = {1'b0, {(VALUE_W-1){1'b1}}};

endpackage

>>> rtl/can_signal_extract_scale_core.sv
// ----------------------------------------------------------------------------
// can_signal_extract_scale_core
// cuts one configured signal out of a can payload and scales it to Q32.16
// ----------------------------------------------------------------------------
// throughput: one payload per cycle while the output is not stalled, set by a 7 register pipeline
//   (input, extract, sign, split 32x32 multiply, saturate, offset, clamp)
// a stalled output fills the pipeline stage by stage before input ready drops
// reset: asynchronous active low; clears all stage valid bits and loads the
//   configuration registers with their documented defaults
module can_signal_extract_scale_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // apb configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [cses_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [cses_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [cses_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready,
  // input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [cses_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [63:0] payload
  // output stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [cses_pkg::OUT_TDATA_W-1:0]     m_axis_tdata   // [63:0] raw_field,
                                                              // [111:64] physical_value
);
  import cses_pkg::*;

  // configuration registers
  logic [5:0]         start_bit_q;
  logic [6:0]         bit_length_q;
  logic               intel_order_q;
  logic               is_unsigned_q;
  logic [SCALE_W-1:0] scale_factor_q;
  logic [VALUE_W-1:0] offset_value_q;
  logic [VALUE_W-1:0] min_limit_q;
  logic [VALUE_W-1:0] max_limit_q;

  reg_idx_e reg_idx;
  logic     cfg_wr;

  assign reg_idx = reg_idx_e'(paddr[5:3]);
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_bit_q    <= START_BIT_RST;
      bit_length_q   <= BIT_LENGTH_RST;
      intel_order_q  <= 1'b1;
      is_unsigned_q  <= 1'b1;
      scale_factor_q <= SCALE_RST;
      offset_value_q <= OFFSET_RST;
      min_limit_q    <= MIN_RST;
      max_limit_q    <= MAX_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_START_BIT:    start_bit_q    <= pwdata[5:0];
        REG_BIT_LENGTH:   bit_length_q   <= pwdata[6:0];
        REG_INTEL_ORDER:  intel_order_q  <= pwdata[0];
        REG_IS_UNSIGNED:  is_unsigned_q  <= pwdata[0];
        REG_SCALE_FACTOR: scale_factor_q <= pwdata[SCALE_W-1:0];
        REG_OFFSET_VALUE: offset_value_q <= pwdata[VALUE_W-1:0];
        REG_MIN_LIMIT:    min_limit_q    <= pwdata[VALUE_W-1:0];
        REG_MAX_LIMIT:    max_limit_q    <= pwdata[VALUE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_START_BIT:    prdata = APB_DATA_W'(start_bit_q);
      REG_BIT_LENGTH:   prdata = APB_DATA_W'(bit_length_q);
      REG_INTEL_ORDER:  prdata = APB_DATA_W'(intel_order_q);
      REG_IS_UNSIGNED:  prdata = APB_DATA_W'(is_unsigned_q);
      REG_SCALE_FACTOR: prdata = APB_DATA_W'(scale_factor_q);
      REG_OFFSET_VALUE: prdata = APB_DATA_W'(offset_value_q);
      REG_MIN_LIMIT:    prdata = APB_DATA_W'(min_limit_q);
      REG_MAX_LIMIT:    prdata = APB_DATA_W'(max_limit_q);
      default:          prdata = '0;
    endcase
  end

  // static values derived from configuration
  logic [6:0]         len_eff;
  logic [RAW_W-1:0]   len_mask;
  logic [5:0]         msb_idx;
  logic [5:0]         moto_pos;
  logic [SCALE_W-1:0] scale_mag;

  assign len_eff   = (bit_length_q > 7'd64) ? 7'd64 : bit_length_q;
  assign len_mask  = (len_eff >= 7'd64) ? {RAW_W{1'b1}}
                                        : RAW_W'((65'd1 << len_eff) - 65'd1);
  assign msb_idx   = 6'(len_eff - 7'd1);
  // motorola start bit renumbered from the msb of byte 0
  assign moto_pos  = {start_bit_q[5:3], ~start_bit_q[2:0]};
  assign scale_mag = scale_factor_q[SCALE_W-1] ? (~scale_factor_q + 1'b1) : scale_factor_q;

  // stage handshake: a stage loads when empty or when the next one moves
  logic [N_STAGES-1:0] v_q;
  logic [N_STAGES-1:0] rdy;
  logic [N_STAGES-1:0] v_in;

  always_comb begin
    rdy[N_STAGES-1] = ~v_q[N_STAGES-1] | m_axis_tready;
    for (int k = N_STAGES - 2; k >= 0; k--) begin
      rdy[k] = ~v_q[k] | rdy[k+1];
    end
  end

  assign v_in          = {v_q[N_STAGES-2:0], s_axis_tvalid};
  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = v_q[N_STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < N_STAGES; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  // stage 1: payload register, field extraction
  logic [PAYLOAD_W-1:0] payload_q;
  logic [PAYLOAD_W-1:0] data_s1;
  logic [PAYLOAD_W-1:0] swapped_s1;
  logic [RAW_W-1:0]     raw_s1;

  always_comb begin
    data_s1 = payload_q & PAYLOAD_MASK;
    for (int i = 0; i < 8; i++) begin
      swapped_s1[8*i +: 8] = data_s1[8*(7-i) +: 8];
    end
    if (intel_order_q) begin
      raw_s1 = (data_s1 >> start_bit_q) & len_mask;
    end else begin
      // shift by 64 clears the field when the length is zero
      raw_s1 = (swapped_s1 << moto_pos) >> (7'd64 - len_eff);
    end
  end

  // stage 2: sign handling to magnitude
  logic [RAW_W-1:0]   raw2_q;
  logic               neg_s2;
  logic [RAW_W-1:0]   mag_s2;

  assign neg_s2 = ~is_unsigned_q & (len_eff != 7'd0) & raw2_q[msb_idx];
  assign mag_s2 = neg_s2 ? ((~raw2_q & len_mask) + 1'b1) : raw2_q;

  // stage 3: split multiply into two 32x32 partial products
  logic [RAW_W-1:0]   raw3_q;
  logic [RAW_W-1:0]   mag_q;
  logic [SCALE_W-1:0] ms_q;
  logic               pneg3_q;
  logic [WIDE_W-1:0]  hi_s3;
  logic [WIDE_W-1:0]  lo_s3;

  assign hi_s3 = mag_q[63:32] * ms_q;
  assign lo_s3 = mag_q[31:0] * ms_q;

  // stage 4: recombine and saturate magnitude
  logic [RAW_W-1:0]   raw4_q;
  logic [WIDE_W-1:0]  hi_q;
  logic [WIDE_W-1:0]  lo_q;
  logic               pneg4_q;
  logic [WIDE_W:0]    psum_s4;
  logic [WIDE_W-1:0]  pm_s4;

  assign psum_s4 = {1'b0, hi_q[31:0], 32'd0} + {1'b0, lo_q};
  assign pm_s4   = ((hi_q[63:30] != '0) || psum_s4[WIDE_W] ||
                    (psum_s4[WIDE_W-1:0] > PROD_CAP)) ? PROD_CAP : psum_s4[WIDE_W-1:0];

  // stage 5: signed product plus offset
  logic [RAW_W-1:0]         raw5_q;
  logic [WIDE_W-1:0]        pm_q;
  logic                     pneg5_q;
  logic signed [WIDE_W-1:0] off_s5;
  logic signed [WIDE_W-1:0] sum_s5;

  assign off_s5 = WIDE_W'(signed'(offset_value_q));
  assign sum_s5 = pneg5_q ? (off_s5 - signed'(pm_q)) : (off_s5 + signed'(pm_q));

  // stage 6: clamp, upper limit first so the lower limit wins when crossed
  logic [RAW_W-1:0]         raw6_q;
  logic signed [WIDE_W-1:0] sum_q;
  logic signed [WIDE_W-1:0] hi_lim;
  logic signed [WIDE_W-1:0] lo_lim;
  logic signed [WIDE_W-1:0] upper_s6;
  logic signed [WIDE_W-1:0] clamp_s6;

  assign hi_lim   = WIDE_W'(signed'(max_limit_q));
  assign lo_lim   = WIDE_W'(signed'(min_limit_q));
  assign upper_s6 = (sum_q > hi_lim) ? hi_lim : sum_q;
  assign clamp_s6 = (upper_s6 < lo_lim) ? lo_lim : upper_s6;

  // output register
  logic [RAW_W-1:0]   raw_out_q;
  logic [VALUE_W-1:0] phys_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      payload_q <= s_axis_tdata[PAYLOAD_W-1:0];
    end
    if (rdy[1]) begin
      raw2_q <= raw_s1;
    end
    if (rdy[2]) begin
      raw3_q  <= raw2_q;
      mag_q   <= mag_s2;
      ms_q    <= scale_mag;
      pneg3_q <= neg_s2 ^ scale_factor_q[SCALE_W-1];
    end
    if (rdy[3]) begin
      raw4_q  <= raw3_q;
      hi_q    <= hi_s3;
      lo_q    <= lo_s3;
      pneg4_q <= pneg3_q;
    end
    if (rdy[4]) begin
      raw5_q  <= raw4_q;
      pm_q    <= pm_s4;
      pneg5_q <= pneg4_q;
    end
    if (rdy[5]) begin
      raw6_q <= raw5_q;
      sum_q  <= sum_s5;
    end
    if (rdy[6]) begin
      raw_out_q <= raw6_q;
      phys_q    <= clamp_s6[VALUE_W-1:0];
    end
  end

  assign m_axis_tdata = {phys_q, raw_out_q};

  // an empty output register never blocks the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[N_STAGES-1] |-> s_axis_tready)
    else $error("input stalled with empty output register");

  // a held multiply stage keeps its partial products
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(v_q[3] && !rdy[4]) |-> (v_q[3] && $stable(hi_q) && $stable(lo_q)))
    else $error("stalled multiply stage lost its request");

  // saturated product magnitude never exceeds the cap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[4] |-> (pm_q <= PROD_CAP))
    else $error("product magnitude above saturation bound");

endmodule
